[hw/rtl/bcmp_pkg.sv]
// shared types, constants and a helper function for the barometer compensation block
// no dependencies
package bcmp_pkg;

    localparam int unsigned DivSteps = 32;

    localparam logic signed [31:0] TempOffset = 32'sd4000;
    localparam logic signed [31:0] PressScale = 32'sd50000;
    localparam logic signed [31:0] CoefP2 = 32'sd3038;
    localparam logic signed [31:0] CoefP1 = -32'sd7357;
    localparam logic signed [31:0] CoefP0 = 32'sd3791;
    localparam logic signed [31:0] B4Offset = 32'sd32768;
    localparam logic signed [31:0] TempMin = -32'sd32768;
    localparam logic signed [31:0] TempMax = 32'sd32767;
    localparam logic signed [31:0] PressMax = 32'sd262143;

    localparam logic [1:0] RegOversampling = 2'd0;
    localparam logic [1:0] RegCoeffA = 2'd1;
    localparam logic [1:0] RegCoeffB = 2'd2;
    localparam logic [1:0] RegCoeffC = 2'd3;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } in_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [17:0] pressure_pa;
        logic divide_error;
    } out_t;

    typedef struct packed {
        logic err;
        logic neg;
        logic big;
        logic signed [31:0] x1;
        logic [18:0] up;
        logic signed [15:0] t;
    } side_t;

    // signed division by 2**k truncating toward zero
    function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] x,
                                                     input int unsigned k);
        logic [31:0] bias;
        logic signed [31:0] sum;
        bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        sum = x + $signed(bias);
        return sum >>> k;
    endfunction

endpackage

[hw/rtl/barometer_compensation_top.sv]
// throughput: one transaction per cycle unless stalled; two 32-stage pipelined dividers set the depth
// the whole pipeline holds while the output register waits for out_ready
// reset clears all valid bits and the configuration registers to zero
// top level of the barometer compensation pipeline
// depends on bcmp_pkg and bcmp_udiv
module barometer_compensation_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bcmp_pkg::in_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bcmp_pkg::out_t    out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data
);

    logic [1:0]  oss_reg;
    logic [63:0] coeff_a_reg;
    logic [63:0] coeff_b_reg;
    logic [31:0] coeff_c_reg;

    logic signed [31:0] c1, c2, c3, c4, c5, c6, b1, b2, mc, md;
    logic signed [31:0] press_mul;

    assign c1 = 32'(signed'(coeff_a_reg[63:48]));
    assign c2 = 32'(signed'(coeff_a_reg[47:32]));
    assign c3 = 32'(signed'(coeff_a_reg[31:16]));
    assign c4 = $signed({16'd0, coeff_a_reg[15:0]});
    assign c5 = $signed({16'd0, coeff_b_reg[63:48]});
    assign c6 = $signed({16'd0, coeff_b_reg[47:32]});
    assign b1 = 32'(signed'(coeff_b_reg[31:16]));
    assign b2 = 32'(signed'(coeff_b_reg[15:0]));
    assign mc = 32'(signed'(coeff_c_reg[31:16]));
    assign md = 32'(signed'(coeff_c_reg[15:0]));
    assign press_mul = bcmp_pkg::PressScale >>> oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg <= 2'd0;
            coeff_a_reg <= 64'd0;
            coeff_b_reg <= 64'd0;
            coeff_c_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bcmp_pkg::RegOversampling: oss_reg <= cfg_data[1:0];
                bcmp_pkg::RegCoeffA:       coeff_a_reg <= cfg_data;
                bcmp_pkg::RegCoeffB:       coeff_b_reg <= cfg_data;
                bcmp_pkg::RegCoeffC:       coeff_c_reg <= cfg_data[31:0];
                default:                   oss_reg <= oss_reg;
            endcase
        end
    end

    logic en;
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    // stage valid bits
    logic s1_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg;
    logic s9_valid_reg, s10_valid_reg, s11_valid_reg, out_valid_reg;
    logic d1_valid, d2_valid;

    // stage payloads
    logic signed [31:0] s1_prod_reg;
    logic [18:0]        s1_up_reg;
    logic signed [31:0] s3_b6_reg;
    bcmp_pkg::side_t    s3_side_reg;
    logic signed [31:0] s4_sqp_reg, s4_c2b6_reg, s4_c3b6_reg;
    bcmp_pkg::side_t    s4_side_reg;
    logic signed [31:0] s5_b2sq_reg, s5_b1sq_reg, s5_x2a_reg, s5_x1b_reg;
    bcmp_pkg::side_t    s5_side_reg;
    logic signed [31:0] s6_b3_reg, s6_x3b_reg;
    bcmp_pkg::side_t    s6_side_reg;
    logic [31:0]        s7_m4_reg, s7_b7_reg;
    bcmp_pkg::side_t    s7_side_reg;
    logic signed [31:0] s9_p_reg;
    bcmp_pkg::side_t    s9_side_reg;
    logic signed [31:0] s10_p_reg, s10_sqr_reg, s10_m7_reg;
    bcmp_pkg::side_t    s10_side_reg;
    logic signed [31:0] s11_p_reg, s11_m3_reg, s11_x2_reg;
    bcmp_pkg::side_t    s11_side_reg;
    bcmp_pkg::out_t     out_reg;

    // stage 1: raw temperature product
    logic signed [31:0] s1_diff, s1_prod_next;
    assign s1_diff = $signed({16'd0, in_data.raw_temperature}) - c6;
    assign s1_prod_next = s1_diff * c5;

    // divider 1 operands: x2 = mc * 2048 / (x1 + md)
    logic signed [31:0] d1_x1, d1_dv, d1_num;
    logic [31:0]        d1_ua, d1_ub, d1_q;
    bcmp_pkg::side_t    d1_side_in, d1_side_out;
    always_comb
    begin
        d1_x1 = bcmp_pkg::sdiv_pow2(s1_prod_reg, 15);
        d1_dv = d1_x1 + md;
        d1_num = mc <<< 11;
        d1_ua = d1_num[31] ? 32'(-d1_num) : d1_num;
        d1_ub = d1_dv[31] ? 32'(-d1_dv) : d1_dv;
        d1_side_in = '0;
        d1_side_in.err = (d1_dv == 32'sd0);
        d1_side_in.neg = d1_num[31] ^ d1_dv[31];
        d1_side_in.x1 = d1_x1;
        d1_side_in.up = s1_up_reg;
        if (d1_side_in.err)
            d1_ub = 32'd1;
    end

    bcmp_udiv u_div_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .dividend  (d1_ua),
        .divisor   (d1_ub),
        .in_side   (d1_side_in),
        .out_valid (d1_valid),
        .quotient  (d1_q),
        .out_side  (d1_side_out)
    );

    // stage 3: b5, temperature, b6
    logic signed [31:0] s3_x2, s3_b5, s3_t;
    bcmp_pkg::side_t    s3_side_next;
    always_comb
    begin
        s3_x2 = d1_side_out.neg ? 32'(-$signed(d1_q)) : $signed(d1_q);
        s3_b5 = d1_side_out.x1 + s3_x2;
        s3_t = bcmp_pkg::sdiv_pow2(s3_b5 + 32'sd8, 4);
        s3_side_next = d1_side_out;
        if (s3_t < bcmp_pkg::TempMin)
            s3_side_next.t = 16'(bcmp_pkg::TempMin);
        else if (s3_t > bcmp_pkg::TempMax)
            s3_side_next.t = 16'(bcmp_pkg::TempMax);
        else
            s3_side_next.t = 16'(s3_t);
    end

    // stage 6: b3 and x3 of the b4 path
    logic signed [31:0] s6_x1a, s6_x2b, s6_sum, s6_shift, s6_b3_next, s6_x3b_next;
    always_comb
    begin
        s6_x1a = bcmp_pkg::sdiv_pow2(s5_b2sq_reg, 11);
        s6_x2b = bcmp_pkg::sdiv_pow2(s5_b1sq_reg, 16);
        s6_sum = (c1 <<< 2) + s6_x1a + s5_x2a_reg;
        s6_shift = s6_sum << oss_reg;
        s6_b3_next = bcmp_pkg::sdiv_pow2(s6_shift + 32'sd2, 2);
        s6_x3b_next = bcmp_pkg::sdiv_pow2(s5_x1b_reg + s6_x2b + 32'sd2, 2);
    end

    // stage 7 products
    logic signed [31:0] s7_m4_next, s7_b7_next;
    assign s7_m4_next = c4 * (s6_x3b_reg + bcmp_pkg::B4Offset);
    assign s7_b7_next = ($signed({13'd0, s6_side_reg.up}) - s6_b3_reg) * press_mul;

    // divider 2 operands: b7 / b4
    logic [31:0]     d2_b4, d2_num, d2_den, d2_q;
    bcmp_pkg::side_t d2_side_in, d2_side_out;
    always_comb
    begin
        d2_b4 = s7_m4_reg >> 15;
        d2_side_in = s7_side_reg;
        d2_side_in.big = s7_b7_reg[31];
        d2_side_in.err = s7_side_reg.err || (d2_b4 == 32'd0);
        d2_num = s7_b7_reg[31] ? s7_b7_reg : (s7_b7_reg << 1);
        d2_den = (d2_b4 == 32'd0) ? 32'd1 : d2_b4;
    end

    bcmp_udiv u_div_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s7_valid_reg),
        .dividend  (d2_num),
        .divisor   (d2_den),
        .in_side   (d2_side_in),
        .out_valid (d2_valid),
        .quotient  (d2_q),
        .out_side  (d2_side_out)
    );

    logic signed [31:0] s9_p_next;
    assign s9_p_next = d2_side_out.big ? $signed(d2_q << 1) : $signed(d2_q);

    logic signed [31:0] s10_pd;
    assign s10_pd = bcmp_pkg::sdiv_pow2(s9_p_reg, 8);

    // final correction and saturation, zeroing on divide error
    logic signed [31:0] o_x1, o_p;
    bcmp_pkg::out_t     out_next;
    always_comb
    begin
        o_x1 = bcmp_pkg::sdiv_pow2(s11_m3_reg, 16);
        o_p = s11_p_reg
            + bcmp_pkg::sdiv_pow2(o_x1 + s11_x2_reg + bcmp_pkg::CoefP0, 4);
        out_next.divide_error = s11_side_reg.err;
        out_next.temperature_tenths = s11_side_reg.t;
        if (o_p < 32'sd0)
            out_next.pressure_pa = 18'd0;
        else if (o_p > bcmp_pkg::PressMax)
            out_next.pressure_pa = 18'(bcmp_pkg::PressMax);
        else
            out_next.pressure_pa = 18'(o_p);
        if (s11_side_reg.err)
        begin
            out_next.temperature_tenths = 16'sd0;
            out_next.pressure_pa = 18'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s3_valid_reg <= d1_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s9_valid_reg <= d2_valid;
            s10_valid_reg <= s9_valid_reg;
            s11_valid_reg <= s10_valid_reg;
            out_valid_reg <= s11_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_up_reg <= in_data.raw_pressure;
            s3_b6_reg <= s3_b5 - bcmp_pkg::TempOffset;
            s3_side_reg <= s3_side_next;
            s4_sqp_reg <= s3_b6_reg * s3_b6_reg;
            s4_c2b6_reg <= c2 * s3_b6_reg;
            s4_c3b6_reg <= c3 * s3_b6_reg;
            s4_side_reg <= s3_side_reg;
            s5_b2sq_reg <= b2 * bcmp_pkg::sdiv_pow2(s4_sqp_reg, 12);
            s5_b1sq_reg <= b1 * bcmp_pkg::sdiv_pow2(s4_sqp_reg, 12);
            s5_x2a_reg <= bcmp_pkg::sdiv_pow2(s4_c2b6_reg, 11);
            s5_x1b_reg <= bcmp_pkg::sdiv_pow2(s4_c3b6_reg, 13);
            s5_side_reg <= s4_side_reg;
            s6_b3_reg <= s6_b3_next;
            s6_x3b_reg <= s6_x3b_next;
            s6_side_reg <= s5_side_reg;
            s7_m4_reg <= s7_m4_next;
            s7_b7_reg <= s7_b7_next;
            s7_side_reg <= s6_side_reg;
            s9_p_reg <= s9_p_next;
            s9_side_reg <= d2_side_out;
            s10_p_reg <= s9_p_reg;
            s10_sqr_reg <= s10_pd * s10_pd;
            s10_m7_reg <= bcmp_pkg::CoefP1 * s9_p_reg;
            s10_side_reg <= s9_side_reg;
            s11_p_reg <= s10_p_reg;
            s11_m3_reg <= s10_sqr_reg * bcmp_pkg::CoefP2;
            s11_x2_reg <= bcmp_pkg::sdiv_pow2(s10_m7_reg, 16);
            s11_side_reg <= s10_side_reg;
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.divide_error |->
            out_data.temperature_tenths == 16'sd0 && out_data.pressure_pa == 18'd0)
        else $error("divide error with nonzero result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(s11_valid_reg) && $stable(s1_valid_reg))
        else $error("pipeline moved during stall");

    a_no_accept_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid |-> out_ready)
        else $error("input transaction taken while output stalled");

endmodule

[hw/rtl/bcmp_udiv.sv]
// pipelined 32 by 32 bit unsigned divider, one quotient bit per stage
// depends on bcmp_pkg
module bcmp_udiv (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         dividend,
    input  logic [31:0]         divisor,
    input  bcmp_pkg::side_t     in_side,
    output logic                out_valid,
    output logic [31:0]         quotient,
    output bcmp_pkg::side_t     out_side
);

    logic            valid_reg [bcmp_pkg::DivSteps];
    logic [31:0]     rem_reg   [bcmp_pkg::DivSteps];
    logic [31:0]     num_reg   [bcmp_pkg::DivSteps];
    logic [31:0]     div_reg   [bcmp_pkg::DivSteps];
    bcmp_pkg::side_t side_reg  [bcmp_pkg::DivSteps];

    logic [31:0]     rem_next  [bcmp_pkg::DivSteps];
    logic [31:0]     num_next  [bcmp_pkg::DivSteps];

    always_comb
    begin
        for (int k = 0; k < bcmp_pkg::DivSteps; k++)
        begin
            logic [31:0] rem_src;
            logic [31:0] num_src;
            logic [31:0] div_src;
            logic [32:0] trial;
            rem_src = (k == 0) ? 32'd0 : rem_reg[(k == 0) ? 0 : k - 1];
            num_src = (k == 0) ? dividend : num_reg[(k == 0) ? 0 : k - 1];
            div_src = (k == 0) ? divisor : div_reg[(k == 0) ? 0 : k - 1];
            trial = {rem_src, num_src[31]};
            if (trial >= {1'b0, div_src})
            begin
                rem_next[k] = 32'(trial - {1'b0, div_src});
                num_next[k] = {num_src[30:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[31:0];
                num_next[k] = {num_src[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < bcmp_pkg::DivSteps; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < bcmp_pkg::DivSteps; k++)
                valid_reg[k] <= valid_reg[k - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0] <= divisor;
            side_reg[0] <= in_side;
            for (int k = 1; k < bcmp_pkg::DivSteps; k++)
            begin
                div_reg[k] <= div_reg[k - 1];
                side_reg[k] <= side_reg[k - 1];
            end
            for (int k = 0; k < bcmp_pkg::DivSteps; k++)
            begin
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= num_next[k];
            end
        end
    end

    assign out_valid = valid_reg[bcmp_pkg::DivSteps - 1];
    assign quotient  = num_reg[bcmp_pkg::DivSteps - 1];
    assign out_side  = side_reg[bcmp_pkg::DivSteps - 1];

endmodule

[tb/tb_top.sv]
// testbench for barometer_compensation_top: directed table and calibration cases, then random readings
// depends on bcmp_pkg and the barometer compensation rtl
module tb_top;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    bcmp_pkg::in_t in_data;
    logic out_valid;
    logic out_ready;
    bcmp_pkg::out_t out_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [63:0] cfg_data;

    barometer_compensation_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct {
        logic [15:0] ut;
        logic [18:0] up;
        logic check_fixed;
        bcmp_pkg::out_t fixed;
    } row_t;

    logic [1:0] oss_q;
    logic [63:0] coeff_a_q;
    logic [63:0] coeff_b_q;
    logic [31:0] coeff_c_q;
    bcmp_pkg::out_t pending_q[$];
    int error_count;
    int reading_count;
    int result_count;
    int idle_cycles;
    logic calm;
    row_t dir_rows[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [31:0] div_trunc(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic signed [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic bcmp_pkg::out_t compensate(input logic [15:0] ut,
                                                  input logic [18:0] up);
        logic signed [31:0] c1, c2, c3, c5, c6, b1, b2, mc, md;
        logic signed [31:0] x1, x2, x3, b5, b6, b3, t, p, dv, sq;
        logic [31:0] c4, b4, b7, pu;
        logic [63:0] wide;
        bcmp_pkg::out_t r;
        c1 = sext16(coeff_a_q[63:48]);
        c2 = sext16(coeff_a_q[47:32]);
        c3 = sext16(coeff_a_q[31:16]);
        c4 = {16'd0, coeff_a_q[15:0]};
        c5 = {16'd0, coeff_b_q[63:48]};
        c6 = {16'd0, coeff_b_q[47:32]};
        b1 = sext16(coeff_b_q[31:16]);
        b2 = sext16(coeff_b_q[15:0]);
        mc = sext16(coeff_c_q[31:16]);
        md = sext16(coeff_c_q[15:0]);
        r.temperature_tenths = '0;
        r.pressure_pa = '0;
        r.divide_error = 1'b1;
        x1 = div_trunc(({16'd0, ut} - c6) * c5, 32768);
        dv = x1 + md;
        if (dv == 0)
            return r;
        x2 = div_trunc(mc * 2048, dv);
        b5 = x1 + x2;
        t = div_trunc(b5 + 8, 16);
        b6 = b5 - 4000;
        sq = div_trunc(b6 * b6, 4096);
        x1 = div_trunc(b2 * sq, 2048);
        x2 = div_trunc(c2 * b6, 2048);
        x3 = x1 + x2;
        b3 = (c1 * 4 + x3) << oss_q;
        b3 = div_trunc(b3 + 2, 4);
        x1 = div_trunc(c3 * b6, 8192);
        x2 = div_trunc(b1 * sq, 65536);
        x3 = div_trunc(x1 + x2 + 2, 4);
        wide = 64'(c4) * 64'(x3 + 32'sd32768);
        b4 = wide[31:0] / 32'd32768;
        if (b4 == 0)
            return r;
        b7 = ({13'd0, up} - b3) * (32'd50000 >> oss_q);
        if (b7 < 32'h80000000)
            pu = (b7 * 2) / b4;
        else
            pu = (b7 / b4) * 2;
        p = pu;
        x1 = div_trunc(p, 256) * div_trunc(p, 256);
        x1 = div_trunc(x1 * 3038, 65536);
        x2 = div_trunc(-32'sd7357 * p, 65536);
        p = p + div_trunc(x1 + x2 + 3791, 16);
        if (t < -32768)
            t = -32768;
        if (t > 32767)
            t = 32767;
        if (p < 0)
            p = 0;
        if (p > 262143)
            p = 262143;
        r.temperature_tenths = t[15:0];
        r.pressure_pa = p[17:0];
        r.divide_error = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
                 result_count);
        error_count++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bcmp_pkg::RegOversampling: oss_q = val[1:0];
            bcmp_pkg::RegCoeffA: coeff_a_q = val;
            bcmp_pkg::RegCoeffB: coeff_b_q = val;
            default: coeff_c_q = val[31:0];
        endcase
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (90) @(posedge clk);
    endtask

    task automatic send_reading(input logic [15:0] ut, input logic [18:0] up,
                                input logic use_fixed, input bcmp_pkg::out_t fixed);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{raw_temperature: ut, raw_pressure: up};
        pending_q.push_back(use_fixed ? fixed : compensate(ut, up));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        reading_count++;
    endtask

    // typical factory calibration set
    task automatic load_typical(input logic [1:0] oss);
        write_reg(bcmp_pkg::RegOversampling, {62'd0, oss});
        write_reg(bcmp_pkg::RegCoeffA, {16'd408, -16'sd72, -16'sd14383, 16'd32741});
        write_reg(bcmp_pkg::RegCoeffB, {16'd32757, 16'd23153, 16'sd6190, 16'sd4});
        write_reg(bcmp_pkg::RegCoeffC, {32'd0, -16'sd8711, 16'sd2868});
    endtask

    task automatic random_phase(input int n, input logic shaped);
        logic [15:0] ut;
        logic [18:0] up;
        for (int i = 0; i < n; i++)
        begin
            if (shaped && $urandom_range(0, 3) != 0)
            begin
                ut = 16'($urandom_range(20000, 35000));
                up = 19'($urandom_range(20000, 120000) << oss_q);
            end
            else
            begin
                ut = 16'($urandom);
                up = 19'($urandom);
            end
            send_reading(ut, up, 1'b0, '0);
        end
    endtask

    task automatic random_coeffs;
        write_reg(bcmp_pkg::RegOversampling, {32'd0, $urandom});
        write_reg(bcmp_pkg::RegCoeffA, {$urandom, $urandom});
        write_reg(bcmp_pkg::RegCoeffB, {$urandom, $urandom});
        write_reg(bcmp_pkg::RegCoeffC, {32'd0, $urandom});
    endtask

    // output side: random stalls, compare against oldest expectation
    always @(posedge clk)
    begin
        bcmp_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("unexpected result transaction %0h", out_data);
                error_count++;
            end
            else
            begin
                want = pending_q.pop_front();
                if (out_data.temperature_tenths !== want.temperature_tenths)
                    report_mismatch("temperature_tenths", out_data.temperature_tenths,
                                    want.temperature_tenths);
                if (out_data.pressure_pa !== want.pressure_pa)
                    report_mismatch("pressure_pa", out_data.pressure_pa, want.pressure_pa);
                if (out_data.divide_error !== want.divide_error)
                    report_mismatch("divide_error", out_data.divide_error,
                                    want.divide_error);
            end
            result_count++;
        end
    end

    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("watchdog: no transaction for too long");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        bcmp_pkg::out_t z;
        bcmp_pkg::out_t div0;
        z = '0;
        div0 = '{temperature_tenths: 16'sd0, pressure_pa: 18'd0, divide_error: 1'b1};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        error_count = 0;
        reading_count = 0;
        result_count = 0;
        idle_cycles = 0;
        oss_q = '0;
        coeff_a_q = '0;
        coeff_b_q = '0;
        coeff_c_q = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all coefficients zero after reset: divisor zero
        dir_rows.push_back('{16'd0, 19'd0, 1'b1, div0});
        dir_rows.push_back('{16'hffff, 19'h7ffff, 1'b1, div0});
        foreach (dir_rows[i])
            send_reading(dir_rows[i].ut, dir_rows[i].up, dir_rows[i].check_fixed,
                         dir_rows[i].fixed);
        drain();

        for (int o = 0; o < 4; o++)
        begin
            load_typical(o[1:0]);
            send_reading(16'd27898, 19'd23843 << o, 1'b0, z);
            send_reading(16'd0, 19'd0, 1'b0, z);
            send_reading(16'hffff, 19'h7ffff, 1'b0, z);
            send_reading(16'h8000, 19'h40000, 1'b0, z);
            drain();
        end

        // b4 zero: c4 zero with valid temperature path
        write_reg(bcmp_pkg::RegCoeffA, {16'd408, -16'sd72, -16'sd14383, 16'd0});
        send_reading(16'd27898, 19'd23843, 1'b1, div0);
        // extreme coefficient words
        drain();
        write_reg(bcmp_pkg::RegCoeffA, 64'hffff_ffff_ffff_ffff);
        write_reg(bcmp_pkg::RegCoeffB, 64'hffff_ffff_ffff_ffff);
        write_reg(bcmp_pkg::RegCoeffC, 64'hffff_ffff_ffff_ffff);
        send_reading(16'h0000, 19'h7ffff, 1'b0, z);
        send_reading(16'hffff, 19'h00000, 1'b0, z);
        drain();
        write_reg(bcmp_pkg::RegCoeffA, 64'h8000_8000_8000_ffff);
        write_reg(bcmp_pkg::RegCoeffB, 64'hffff_0000_8000_8000);
        write_reg(bcmp_pkg::RegCoeffC, 64'h7fff_7fff);
        send_reading(16'h1234, 19'h5a5a5, 1'b0, z);
        send_reading(16'hedcb, 19'h25a5a, 1'b0, z);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            load_typical(ph[1:0]);
            random_phase(250, 1'b1);
            drain();
        end
        for (int ph = 0; ph < 4; ph++)
        begin
            random_coeffs();
            random_phase(100, 1'b0);
            drain();
        end
        calm = 1'b1;
        load_typical(2'd3);
        random_phase(100, 1'b1);

        drain();
        $display("covered %0d readings, %0d results, all oversampling settings,",
                 reading_count, result_count);
        $display("typical, extreme and random calibration sets, zero divisor cases");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[barometer_compensation_top.f]
hw/rtl/bcmp_pkg.sv
hw/rtl/bcmp_udiv.sv
hw/rtl/barometer_compensation_top.sv
tb/tb_top.sv
